/* sv/process_sandbox_policy_table_assert.svh */
// assertion macros used by the checker file
`ifndef PROCESS_SANDBOX_POLICY_TABLE_ASSERT_SVH
`define PROCESS_SANDBOX_POLICY_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define PSPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sandbox table assertion failed");

// next-cycle implication, sampled on clk, quiet during rst
`define PSPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sandbox table assertion failed");

`endif

/* sv/psp_pkg.sv */
package psp_pkg;

  localparam int SlotsDefault   = 256;
  localparam int FilterEntries  = 512;
  localparam int ProfileCount   = 4;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_SYSCALL = 3'd2;
  localparam logic [2:0] OP_CAP     = 3'd3;
  localparam logic [2:0] OP_UPDATE  = 3'd4;

  localparam logic [2:0] RK_CPU   = 3'd0;
  localparam logic [2:0] RK_MEM   = 3'd1;
  localparam logic [2:0] RK_IO    = 3'd2;
  localparam logic [2:0] RK_FILES = 3'd3;
  localparam logic [2:0] RK_KIDS  = 3'd4;

  localparam logic [63:0] Mib = 64'd1048576;

  // process id memory word
  typedef struct packed {
    logic [1:0]  profile;
    logic [31:0] pid;
  } pid_word_t;

  // per-slot resource and violation word
  typedef struct packed {
    logic [31:0] vtotal;
    logic [31:0] kids;
    logic [31:0] files;
    logic [31:0] io;
    logic [63:0] mem;
    logic [63:0] cpu;
  } res_word_t;

  function automatic logic [31:0] prof_caps(input logic [1:0] p);
    case (p)
      2'd0:    prof_caps = 32'hFFFF_FFFF;
      2'd1:    prof_caps = 32'h0000_0016;
      default: prof_caps = 32'h0;
    endcase
  endfunction

  function automatic logic prof_deny(input logic [1:0] p);
    prof_deny = p[1];
  endfunction

  function automatic logic [63:0] prof_cpu(input logic [1:0] p);
    case (p)
      2'd1:    prof_cpu = 64'd60000;
      2'd2:    prof_cpu = 64'd10000;
      2'd3:    prof_cpu = 64'd30000;
      default: prof_cpu = 64'd0;
    endcase
  endfunction

  function automatic logic [63:0] prof_mem(input logic [1:0] p);
    case (p)
      2'd1:    prof_mem = 64'd100 * Mib;
      2'd2:    prof_mem = 64'd10 * Mib;
      2'd3:    prof_mem = 64'd50 * Mib;
      default: prof_mem = 64'd0;
    endcase
  endfunction

  function automatic logic [31:0] prof_io(input logic [1:0] p);
    case (p)
      2'd1:    prof_io = 32'd10000;
      2'd2:    prof_io = 32'd1000;
      default: prof_io = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] prof_files(input logic [1:0] p);
    case (p)
      2'd0:    prof_files = 32'd1024;
      2'd1:    prof_files = 32'd100;
      2'd2:    prof_files = 32'd10;
      default: prof_files = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] prof_kids(input logic [1:0] p);
    case (p)
      2'd0:    prof_kids = 32'd100;
      2'd1:    prof_kids = 32'd10;
      default: prof_kids = 32'd1;
    endcase
  endfunction

  // syscall exception lists of the profiles
  function automatic logic prof_exception(input logic [1:0] p, input logic [31:0] num);
    logic hit;
    hit = 1'b0;
    case (p)
      2'd1:    hit = (num == 32'd117) || (num == 32'd142) || (num == 32'd275);
      2'd2:    hit = (num == 32'd63) || (num == 32'd64) || (num == 32'd56) ||
                     (num == 32'd57) || (num == 32'd222) || (num == 32'd215) ||
                     (num == 32'd214) || (num == 32'd93);
      2'd3:    hit = (num == 32'd222) || (num == 32'd215) || (num == 32'd214) ||
                     (num == 32'd93);
      default: hit = 1'b0;
    endcase
    prof_exception = hit;
  endfunction

  function automatic logic syscall_denied(input logic [1:0] p, input logic [31:0] num);
    logic exc;
    exc = (num < 32'(FilterEntries)) && prof_exception(p, num);
    syscall_denied = exc ? !prof_deny(p) : prof_deny(p);
  endfunction

endpackage

/* sv/psp_ram.sv */
module psp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/process_sandbox_policy_table.sv */
// Sandbox policy table.
// Input channel s_*: one item per operation, opcode in s_tuser, arguments in s_tdata.
// Output channel m_*: exactly one result item per input item, in order.
// Each item scans the process id memory one slot per cycle from slot 0 until the
// lowest matching slot (a free slot for create) is found, then reads the resource
// memory and writes back any change in the final step; with no match the scan runs
// to the last slot. Unknown opcodes skip the scan and go straight to the final step.
// The final step loads the result into the output register and returns to idle,
// where the next item can be taken. One item is in work at a time; s_tready is
// high only while idle. A finished result sits in the output register while the
// next item is accepted; if the receiver stalls (m_tready low) with a result still
// held, the following item waits in its final step until the register is taken.
// Reset (rst, synchronous) clears the slot valid bits, the active, violation and
// kill counters and the output valid; the memories need no clearing pass.
module process_sandbox_policy_table
  import psp_pkg::*;
#(
  parameter int SLOTS = SlotsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // proc_id, profile_index, syscall_number, capability_mask, resource_kind, amount
  input  logic [167:0] s_tdata,
  // opcode
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // granted, slot_found, violation, killed, slot_index, slot_violations,
  // active_count, total_violation_count, kill_count
  output logic [207:0] m_tdata
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]  state;
  logic [2:0]  op;
  logic [31:0] pid;
  logic [1:0]  pidx;
  logic [31:0] sc;
  logic [31:0] cmask;
  logic [2:0]  kind;
  logic [63:0] amt;

  logic [IW:0]   scan_addr;
  logic          pend;
  logic [IW-1:0] addr_q;
  logic          found;
  logic [IW-1:0] slot;
  logic [1:0]    prof;

  logic [SLOTS-1:0] valid;
  logic [31:0]      active_cnt;
  logic [63:0]      gviol;
  logic [63:0]      gkill;

  pid_word_t pid_rd, pid_wr;
  res_word_t res_rd, res_wr;
  logic      pid_we, res_we;
  logic [IW-1:0] res_raddr;

  logic hit;
  logic proceed;
  logic granted, viol, kill;
  logic set_valid, clr_valid;
  logic [31:0] vt_base;
  logic [31:0] vt_new;
  logic [31:0] active_next;
  logic [63:0] gviol_next;
  logic [63:0] gkill_next;
  logic [63:0] cpu_sum;
  logic [31:0] io_sum;
  logic [7:0]  slot_out;

  assign s_tready = (state == ST_IDLE);
  assign proceed  = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // memories: process id and profile, per-slot resources
  psp_ram #(.WIDTH($bits(pid_word_t)), .DEPTH(SLOTS)) u_pid_ram (
    .clk   (clk),
    .we    (pid_we),
    .waddr (slot),
    .wdata (pid_wr),
    .raddr (scan_addr[IW-1:0]),
    .rdata (pid_rd)
  );

  psp_ram #(.WIDTH($bits(res_word_t)), .DEPTH(SLOTS)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (slot),
    .wdata (res_wr),
    .raddr (res_raddr),
    .rdata (res_rd)
  );

  assign res_raddr = (state == ST_SCAN) ? addr_q : slot;

  // scan compare on the entry read last cycle
  assign hit = pend && ((op == OP_CREATE) ? !valid[addr_q]
                                          : (valid[addr_q] && (pid_rd.pid == pid)));

  // final step: decide, update the slot
  always_comb begin
    granted   = 1'b0;
    viol      = 1'b0;
    kill      = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    pid_we    = 1'b0;
    res_we    = 1'b0;
    active_next = active_cnt;
    pid_wr.pid     = pid;
    pid_wr.profile = pidx;
    res_wr   = res_rd;
    cpu_sum  = res_rd.cpu + amt;
    io_sum   = res_rd.io + amt[31:0];
    vt_base  = res_rd.vtotal;
    case (op)
      OP_CREATE: begin
        if (found) begin
          granted   = 1'b1;
          set_valid = 1'b1;
          pid_we    = 1'b1;
          res_we    = 1'b1;
          res_wr    = '0;
          vt_base   = 32'd0;
          active_next = active_cnt + 32'd1;
        end
      end
      OP_DESTROY: begin
        if (found) begin
          clr_valid   = 1'b1;
          active_next = active_cnt - 32'd1;
        end
      end
      OP_SYSCALL: begin
        if (!found || !syscall_denied(prof, sc)) begin
          granted = 1'b1;
        end else begin
          viol = 1'b1;
        end
      end
      OP_CAP: begin
        if (!found || ((prof_caps(prof) & cmask) != 32'd0)) begin
          granted = 1'b1;
        end else begin
          viol = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (found) begin
          res_we = 1'b1;
          case (kind)
            RK_CPU: begin
              res_wr.cpu = cpu_sum;
              viol = (prof_cpu(prof) != 64'd0) && (cpu_sum > prof_cpu(prof));
            end
            RK_MEM: begin
              res_wr.mem = amt;
              viol = (prof_mem(prof) != 64'd0) && (amt > prof_mem(prof));
            end
            RK_IO: begin
              res_wr.io = io_sum;
              viol = (prof_io(prof) != 32'd0) && (io_sum > prof_io(prof));
            end
            RK_FILES: begin
              res_wr.files = amt[31:0];
              viol = amt[31:0] > prof_files(prof);
            end
            RK_KIDS: begin
              res_wr.kids = amt[31:0];
              viol = amt[31:0] > prof_kids(prof);
            end
            default: viol = 1'b0;
          endcase
          kill      = viol;
          clr_valid = viol;
        end
      end
      default: granted = 1'b0;
    endcase
    vt_new = vt_base + {31'd0, viol};
    if (viol) begin
      res_we = 1'b1;
    end
    res_wr.vtotal = vt_new;
    gviol_next = gviol + {63'd0, viol};
    gkill_next = gkill + {63'd0, kill};
    if (!proceed) begin
      pid_we = 1'b0;
      res_we = 1'b0;
    end
  end

  // reported slot index, low 8 bits
  always_comb begin
    slot_out = 8'd0;
    if (found) begin
      slot_out = 8'(slot);
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      active_cnt <= 32'd0;
      gviol      <= 64'd0;
      gkill      <= 64'd0;
      m_tvalid   <= 1'b0;
      pend       <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !proceed) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser;
            pid   <= s_tdata[31:0];
            pidx  <= s_tdata[33:32];
            sc    <= s_tdata[65:34];
            cmask <= s_tdata[97:66];
            kind  <= s_tdata[100:98];
            amt   <= s_tdata[164:101];
            scan_addr <= '0;
            pend  <= 1'b0;
            found <= 1'b0;
            if (((s_tuser == OP_CREATE) && ({1'b0, s_tdata[33:32]} < 3'(ProfileCount))) ||
                (s_tuser == OP_DESTROY) || (s_tuser == OP_SYSCALL) ||
                (s_tuser == OP_CAP) || (s_tuser == OP_UPDATE)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_SCAN: begin
          addr_q <= scan_addr[IW-1:0];
          if (scan_addr < (IW+1)'(SLOTS)) begin
            pend      <= 1'b1;
            scan_addr <= scan_addr + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (hit) begin
            found <= 1'b1;
            slot  <= addr_q;
            prof  <= pid_rd.profile;
            state <= ST_EXEC;
          end else if (pend && (addr_q == IW'(SLOTS - 1))) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (proceed) begin
            if (set_valid) begin
              valid[slot] <= 1'b1;
            end
            if (clr_valid) begin
              valid[slot] <= 1'b0;
            end
            active_cnt <= active_next;
            gviol      <= gviol_next;
            gkill      <= gkill_next;
            m_tvalid   <= 1'b1;
            m_tdata    <= {4'd0, gkill_next, gviol_next, active_next,
                           (found ? vt_new : 32'd0), slot_out,
                           kill, viol, found, granted};
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sv/psp_checker.sv */
module psp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [207:0] m_tdata
);

`include "process_sandbox_policy_table_assert.svh"

  // a held result stays offered
  `PSPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  // one item in work: input closes after an item is taken
  `PSPT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
  // a kill is always a violation on a found slot
  `PSPT_ASSERT_NOW(a_kill_viol, m_tvalid && m_tdata[3], m_tdata[2] && m_tdata[1])
  // a violation is never granted
  `PSPT_ASSERT_NOW(a_viol_denied, m_tvalid && m_tdata[2], !m_tdata[0] && m_tdata[1])

endmodule

bind process_sandbox_policy_table psp_checker u_psp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
